// ===== src/pqg_pkg.sv =====
// ============================================================================
// pqg_pkg
// Shared types, codes and float helpers for the planar quantized GEMV block.
// ============================================================================
package pqg_pkg;

   // Depth of one quantized block.
   localparam int BLOCK_LEN = 32;

   // Canonical quiet NaN produced by the float unit.
   localparam logic [31:0] FP32_QNAN = 32'h7FC0_0000;
   localparam logic [15:0] BF16_QNAN = 16'h7FC0;

   // Opcodes of an input word.
   localparam logic OPC_LOAD = 1'b0;
   localparam logic OPC_WORD = 1'b1;

   // Code width selections.
   localparam logic [1:0] MODE_3B = 2'd0;
   localparam logic [1:0] MODE_5B = 2'd1;
   localparam logic [1:0] MODE_6B = 2'd2;
   localparam logic [1:0] MODE_7B = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_BITS_MODE  = 2'd0;
   localparam logic [1:0] CSR_BLOCKS     = 2'd1;
   localparam logic [1:0] CSR_ROWS       = 2'd2;
   localparam logic [1:0] CSR_SCALE_FMT  = 2'd3;

   typedef struct packed {
      logic        opcode;
      logic [2:0]  act_row;
      logic [11:0] act_col;
      logic [15:0] act_value;
      logic [31:0] weight_word;
      logic [2:0]  word_index;
      logic [15:0] scale_value;
      logic [6:0]  zero_code;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  row_index;
      logic [15:0] result_value;
      logic        last_row;
   } rsp_word_type;

   typedef enum logic {
      FOP_MUL = 1'b0,
      FOP_ADD = 1'b1
   } fpu_op_type;

   typedef struct packed {
      logic        start;
      fpu_op_type  op;
      logic [31:0] a;
      logic [31:0] b;
   } fpu_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } fpu_rsp_type;

   // The planar words of one block.
   typedef logic [6:0][31:0] wbuf_type;

   // Number of planar words per block for a code width selection.
   function automatic logic [2:0] mode_bits(logic [1:0] mode);
      logic [2:0] n;
      unique case (mode)
         MODE_3B: n = 3'd3;
         MODE_5B: n = 3'd5;
         MODE_6B: n = 3'd6;
         MODE_7B: n = 3'd7;
      endcase
      return n;
   endfunction

   // Gather the code of element k from the bit-planes.
   function automatic logic [6:0] decode_code(logic [1:0] mode, logic [4:0] k, wbuf_type wb);
      logic [31:0] w2;
      logic [31:0] w4;
      logic [31:0] wm;
      logic [6:0]  code;
      w2 = wb[{2'b00, k[4]}] >> {k[3:0], 1'b0};
      w4 = wb[{1'b0, k[4:3]}] >> {k[2:0], 2'b00};
      wm = wb[3'd4 + {2'b00, k[4]}] >> {k[3:0], 1'b0};
      unique case (mode)
         MODE_3B: code = {4'b0000, wb[2][k], w2[1:0]};
         MODE_5B: code = {2'b00, wb[4][k], w4[3:0]};
         MODE_6B: code = {1'b0, wm[1:0], w4[3:0]};
         MODE_7B: code = {wb[6][k], wm[1:0], w4[3:0]};
      endcase
      return code;
   endfunction

   // Exact conversion of a small unsigned integer to fp32.
   function automatic logic [31:0] int7_to_fp32(logic [6:0] v);
      logic [2:0]  p;
      logic [30:0] t;
      logic [31:0] r;
      p = 3'd0;
      for (int i = 0; i < 7; i++) begin
         if (v[i]) begin
            p = 3'(i);
         end
      end
      t = 31'(v) << (5'd23 - 5'(p));
      if (v == 7'd0) begin
         r = 32'd0;
      end else begin
         r = {1'b0, 8'd127 + 8'(p), t[22:0]};
      end
      return r;
   endfunction

   // Exact widening of fp16 to fp32, subnormals included.
   function automatic logic [31:0] fp16_to_fp32(logic [15:0] h);
      logic [4:0]  e;
      logic [9:0]  m;
      logic [3:0]  lz;
      logic [10:0] mn;
      logic [31:0] r;
      e  = h[14:10];
      m  = h[9:0];
      lz = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (m[i]) begin
            lz = 4'(9 - i);
         end
      end
      mn = 11'(m) << (lz + 4'd1);
      if (e == 5'd0) begin
         if (m == 10'd0) begin
            r = {h[15], 31'd0};
         end else begin
            r = {h[15], 8'd112 - 8'(lz), mn[9:0], 13'd0};
         end
      end else if (e == 5'd31) begin
         r = {h[15], 8'hFF, m, 13'd0};
      end else begin
         r = {h[15], 8'(e) + 8'd112, m, 13'd0};
      end
      return r;
   endfunction

   // Round fp32 to bf16, nearest even; any NaN becomes the quiet NaN.
   function automatic logic [15:0] fp32_to_bf16(logic [31:0] u);
      logic [31:0] s;
      if (u[30:23] == 8'hFF && u[22:0] != 23'd0) begin
         return BF16_QNAN;
      end
      s = u + 32'h0000_7FFF + {31'd0, u[16]};
      return s[31:16];
   endfunction

endpackage

// ===== src/planar_quant_gemv_top.sv =====
// ============================================================================
// planar_quant_gemv_top
// One output column of a grouped zero-point quantized GEMV in fp32.
// ============================================================================
// A load or a planar word is taken only while idle. A block's final word starts
// the block's multiply-adds, and no new word is taken until they are done: every step goes through the single
// four-stage fp32 unit and the activation RAM read, one multiply-add at a time.
// After the last block of a column, one result word per row follows, one per
// cycle at best. Synchronous reset clears control, configuration, block scale
// and zero and the accumulators; the activation RAM is not cleared.
module planar_quant_gemv_top
   import pqg_pkg::*;
#(
   parameter int MAX_ROWS  = 8,
   parameter int MAX_DEPTH = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_wdata
);

   localparam int NBLK   = MAX_DEPTH / BLOCK_LEN;
   localparam int ADDR_W = $clog2(MAX_ROWS * MAX_DEPTH);
   localparam int IDX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int RCNT_W = $clog2(MAX_ROWS + 1);
   localparam int BP_W   = (NBLK > 1) ? $clog2(NBLK) : 1;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_ZSCALE = 8'b0000_0010,
      ST_CODE   = 8'b0000_0100,
      ST_WGT    = 8'b0000_1000,
      ST_READ   = 8'b0001_0000,
      ST_XMUL   = 8'b0010_0000,
      ST_ACC    = 8'b0100_0000,
      ST_EMIT   = 8'b1000_0000
   } state_type;

   state_type       state_ff, state_in;
   logic            issued_ff, issued_in;
   logic [4:0]      k_ff, k_in;
   logic [IDX_W-1:0] m_ff, m_in;
   logic [7:0]      cnt_ff, cnt_in;
   logic [BP_W-1:0] blk_pos_ff, blk_pos_in;
   logic [1:0]      bits_mode_ff, bits_mode_in;
   logic [7:0]      blocks_ff, blocks_in;
   logic [3:0]      rows_ff, rows_in;
   logic            scale_fmt_ff, scale_fmt_in;
   logic [15:0]     scale_ff, scale_in;
   logic [6:0]      zero_ff, zero_in;
   wbuf_type        wbuf_ff, wbuf_in;
   logic [31:0]     zscale_ff, zscale_in;
   logic [31:0]     weight_ff, weight_in;
   logic [31:0]     tmp_ff, tmp_in;
   logic [31:0]     acc_ff [MAX_ROWS];
   logic [31:0]     acc_in [MAX_ROWS];

   fpu_req_type     fpu_req;
   fpu_rsp_type     fpu_rsp;

   logic              ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [15:0]       ram_rd_data;

   logic [RCNT_W-1:0] rows_eff;
   logic [11:0]       blocks_eff;
   logic              m_last;
   logic [31:0]       scale_f;
   logic [31:0]       load_addr;
   logic [31:0]       blk_addr;
   logic              load_ok;
   logic [2:0]        word_bits;
   logic [8:0]        cnt_next;

   // Clamped register values and derived addresses.
   always_comb begin
      int r, b;
      r = int'(rows_ff);
      b = int'(blocks_ff);
      rows_eff   = RCNT_W'((r < 1) ? 1 : ((r > MAX_ROWS) ? MAX_ROWS : r));
      blocks_eff = 12'((b < 1) ? 1 : ((b > NBLK) ? NBLK : b));
   end

   assign m_last    = (32'(m_ff) == 32'(rows_eff) - 32'd1);
   assign scale_f   = scale_fmt_ff ? {scale_ff, 16'd0} : fp16_to_fp32(scale_ff);
   assign load_addr = 32'(req_data.act_row) * MAX_DEPTH + 32'(req_data.act_col);
   assign blk_addr  = 32'(m_ff) * MAX_DEPTH + 32'(blk_pos_ff) * BLOCK_LEN + 32'(k_ff);
   assign load_ok   = (32'(req_data.act_row) < MAX_ROWS) &&
                      (32'(req_data.act_col) < MAX_DEPTH);
   assign word_bits = mode_bits(bits_mode_ff);
   assign cnt_next  = 9'(cnt_ff) + 9'd1;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_data.row_index    = 3'(m_ff);
   assign rsp_data.result_value = fp32_to_bf16(acc_ff[m_ff]);
   assign rsp_data.last_row     = m_last;

   // Sequencer: store activations and latch words, run 32 x rows multiply-adds per block, then emit the column.
   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      k_in         = k_ff;
      m_in         = m_ff;
      cnt_in       = cnt_ff;
      blk_pos_in   = blk_pos_ff;
      bits_mode_in = bits_mode_ff;
      blocks_in    = blocks_ff;
      rows_in      = rows_ff;
      scale_fmt_in = scale_fmt_ff;
      scale_in     = scale_ff;
      zero_in      = zero_ff;
      wbuf_in      = wbuf_ff;
      zscale_in    = zscale_ff;
      weight_in    = weight_ff;
      tmp_in       = tmp_ff;
      acc_in       = acc_ff;
      fpu_req      = '{start: 1'b0, op: FOP_MUL, a: 32'd0, b: 32'd0};
      ram_wr_en    = 1'b0;
      ram_wr_addr  = load_addr[ADDR_W-1:0];
      ram_rd_en    = 1'b0;
      ram_rd_addr  = blk_addr[ADDR_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.opcode)
                  OPC_LOAD: begin
                     ram_wr_en = load_ok;
                  end
                  default: begin
                     if (req_data.word_index < word_bits) begin
                        wbuf_in[req_data.word_index] = req_data.weight_word;
                        scale_in = req_data.scale_value;
                        zero_in  = req_data.zero_code;
                        if (req_data.word_index == word_bits - 3'd1) begin
                           k_in     = 5'd0;
                           m_in     = '0;
                           state_in = ST_ZSCALE;
                        end
                     end
                  end
               endcase
            end
         end
         ST_ZSCALE: begin
            fpu_req = '{start: !issued_ff, op: FOP_MUL, a: int7_to_fp32(zero_ff), b: scale_f};
            issued_in = 1'b1;
            if (fpu_rsp.done) begin
               zscale_in = fpu_rsp.result;
               issued_in = 1'b0;
               state_in  = ST_CODE;
            end
         end
         ST_CODE: begin
            fpu_req = '{start: !issued_ff, op: FOP_MUL,
                        a: int7_to_fp32(decode_code(bits_mode_ff, k_ff, wbuf_ff)),
                        b: scale_f};
            issued_in = 1'b1;
            if (fpu_rsp.done) begin
               tmp_in    = fpu_rsp.result;
               issued_in = 1'b0;
               state_in  = ST_WGT;
            end
         end
         ST_WGT: begin
            fpu_req = '{start: !issued_ff, op: FOP_ADD, a: tmp_ff,
                        b: zscale_ff ^ 32'h8000_0000};
            issued_in = 1'b1;
            if (fpu_rsp.done) begin
               weight_in = fpu_rsp.result;
               issued_in = 1'b0;
               m_in      = '0;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_XMUL;
         end
         ST_XMUL: begin
            fpu_req = '{start: !issued_ff, op: FOP_MUL, a: {ram_rd_data, 16'd0},
                        b: weight_ff};
            issued_in = 1'b1;
            if (fpu_rsp.done) begin
               tmp_in    = fpu_rsp.result;
               issued_in = 1'b0;
               state_in  = ST_ACC;
            end
         end
         ST_ACC: begin
            fpu_req = '{start: !issued_ff, op: FOP_ADD, a: acc_ff[m_ff], b: tmp_ff};
            issued_in = 1'b1;
            if (fpu_rsp.done) begin
               acc_in[m_ff] = fpu_rsp.result;
               issued_in    = 1'b0;
               if (m_last) begin
                  m_in = '0;
                  if (k_ff == 5'(BLOCK_LEN - 1)) begin
                     // Block done: count it and emit the column when complete.
                     if (32'(cnt_next) >= 32'(blocks_eff)) begin
                        state_in = ST_EMIT;
                     end else begin
                        cnt_in     = cnt_next[7:0];
                        blk_pos_in = (32'(blk_pos_ff) == NBLK - 1) ? '0 :
                                     blk_pos_ff + 1'b1;
                        state_in   = ST_IDLE;
                     end
                  end else begin
                     k_in     = k_ff + 5'd1;
                     state_in = ST_CODE;
                  end
               end else begin
                  m_in     = m_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (m_last) begin
                  for (int i = 0; i < MAX_ROWS; i++) begin
                     acc_in[i] = 32'd0;
                  end
                  m_in       = '0;
                  cnt_in     = 8'd0;
                  blk_pos_in = '0;
                  state_in   = ST_IDLE;
               end else begin
                  m_in = m_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Configuration writes.
      if (csr_we) begin
         unique case (csr_index)
            CSR_BITS_MODE: bits_mode_in = csr_wdata[1:0];
            CSR_BLOCKS:    blocks_in    = csr_wdata;
            CSR_ROWS:      rows_in      = csr_wdata[3:0];
            CSR_SCALE_FMT: scale_fmt_in = csr_wdata[0];
         endcase
      end
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         k_ff         <= 5'd0;
         m_ff         <= '0;
         cnt_ff       <= 8'd0;
         blk_pos_ff   <= '0;
         bits_mode_ff <= MODE_3B;
         blocks_ff    <= 8'd1;
         rows_ff      <= 4'd1;
         scale_fmt_ff <= 1'b0;
         scale_ff     <= 16'd0;
         zero_ff      <= 7'd0;
         for (int i = 0; i < MAX_ROWS; i++) begin
            acc_ff[i] <= 32'd0;
         end
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         k_ff         <= k_in;
         m_ff         <= m_in;
         cnt_ff       <= cnt_in;
         blk_pos_ff   <= blk_pos_in;
         bits_mode_ff <= bits_mode_in;
         blocks_ff    <= blocks_in;
         rows_ff      <= rows_in;
         scale_fmt_ff <= scale_fmt_in;
         scale_ff     <= scale_in;
         zero_ff      <= zero_in;
         acc_ff       <= acc_in;
      end
      wbuf_ff   <= wbuf_in;
      zscale_ff <= zscale_in;
      weight_ff <= weight_in;
      tmp_ff    <= tmp_in;
   end

   // Activation store.
   pqg_ram #(
      .WIDTH(16),
      .DEPTH(MAX_ROWS * MAX_DEPTH)
   ) act_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(req_data.act_value),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // Shared fp32 multiply / add unit.
   pqg_fpu fpu (
      .clock(clock),
      .reset(reset),
      .req  (fpu_req),
      .rsp  (fpu_rsp)
   );

endmodule

// ===== src/pqg_ram.sv =====
// ============================================================================
// pqg_ram
// Generic single-clock RAM with one write port and one registered read port.
// ============================================================================
module pqg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/pqg_fpu.sv =====
// ============================================================================
// pqg_fpu
// Four-stage IEEE fp32 multiply / add unit, round to nearest even.
// ============================================================================
module pqg_fpu
   import pqg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  fpu_req_type req,
   output fpu_rsp_type rsp
);

   // Operand stage.
   logic        s0_valid_ff;
   fpu_op_type  s0_op_ff;
   logic [31:0] s0_a_ff, s0_b_ff;

   // Raw result stage.
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_sign_ff, s1_sign_in;
   logic signed [10:0] s1_exp_ff, s1_exp_in;
   logic [47:0]        s1_mant_ff, s1_mant_in;
   logic               s1_nan_ff, s1_nan_in;
   logic               s1_inf_ff, s1_inf_in;

   // Normalized stage.
   logic               s2_valid_ff, s2_valid_in;
   logic               s2_sign_ff;
   logic signed [10:0] s2_exp_ff, s2_exp_in;
   logic [47:0]        s2_mant_ff, s2_mant_in;
   logic               s2_nan_ff, s2_inf_ff;
   logic               s2_zero_ff, s2_zero_in;

   // Packed result.
   logic        s3_valid_ff;
   logic [31:0] s3_result_ff, s3_result_in;

   // Unpack, then multiply mantissas or align and add them.
   always_comb begin
      logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, swap;
      logic [23:0] ma, mb, mbig, msml;
      logic [9:0]  ea, eb, ebig, esml, d;
      logic        sbig, ssml, st;
      logic [5:0]  dd;
      logic [95:0] ext;
      logic [47:0] al, bl;
      sa     = s0_a_ff[31];
      sb     = s0_b_ff[31];
      a_nan  = (s0_a_ff[30:23] == 8'hFF) && (s0_a_ff[22:0] != 23'd0);
      b_nan  = (s0_b_ff[30:23] == 8'hFF) && (s0_b_ff[22:0] != 23'd0);
      a_inf  = (s0_a_ff[30:23] == 8'hFF) && (s0_a_ff[22:0] == 23'd0);
      b_inf  = (s0_b_ff[30:23] == 8'hFF) && (s0_b_ff[22:0] == 23'd0);
      a_zero = (s0_a_ff[30:0] == 31'd0);
      b_zero = (s0_b_ff[30:0] == 31'd0);
      ma     = {s0_a_ff[30:23] != 8'd0, s0_a_ff[22:0]};
      mb     = {s0_b_ff[30:23] != 8'd0, s0_b_ff[22:0]};
      ea     = (s0_a_ff[30:23] == 8'd0) ? 10'd1 : 10'(s0_a_ff[30:23]);
      eb     = (s0_b_ff[30:23] == 8'd0) ? 10'd1 : 10'(s0_b_ff[30:23]);
      swap   = s0_a_ff[30:0] < s0_b_ff[30:0];
      mbig   = swap ? mb : ma;
      msml   = swap ? ma : mb;
      ebig   = swap ? eb : ea;
      esml   = swap ? ea : eb;
      sbig   = swap ? sb : sa;
      ssml   = swap ? sa : sb;
      d      = ebig - esml;
      dd     = (d > 10'd48) ? 6'd48 : d[5:0];
      ext    = {1'b0, msml, 23'd0, 48'd0} >> dd;
      st     = |ext[47:0];
      al     = {1'b0, mbig, 23'd0};
      bl     = {ext[95:49], ext[48] | st};
      s1_valid_in = s0_valid_ff;
      if (s0_op_ff == FOP_MUL) begin
         s1_sign_in = sa ^ sb;
         s1_exp_in  = 11'(ea) + 11'(eb) - 11'sd127;
         s1_mant_in = ma * mb;
         s1_nan_in  = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
         s1_inf_in  = a_inf | b_inf;
      end else begin
         s1_exp_in  = 11'(ebig);
         s1_mant_in = (sbig == ssml) ? (al + bl) : (al - bl);
         s1_sign_in = (s1_mant_in == 48'd0) ? (sa & sb) : sbig;
         s1_nan_in  = a_nan | b_nan | (a_inf & b_inf & (sa != sb));
         s1_inf_in  = a_inf | b_inf;
      end
   end

   // Leading one search and left normalization.
   always_comb begin
      logic [5:0] lz;
      lz = 6'd0;
      for (int i = 0; i < 48; i++) begin
         if (s1_mant_ff[i]) begin
            lz = 6'(47 - i);
         end
      end
      s2_valid_in = s1_valid_ff;
      s2_zero_in  = (s1_mant_ff == 48'd0);
      s2_mant_in  = s1_mant_ff << lz;
      s2_exp_in   = s1_exp_ff + 11'sd1 - $signed(11'(lz));
   end

   // Denormalize if needed, round and pack. An exact zero is settled before
   // the overflow test, since its exponent field carries no meaning.
   always_comb begin
      logic [10:0] shamt;
      logic [5:0]  sh;
      logic [97:0] ext;
      logic [47:0] ms;
      logic        st, inc;
      logic [9:0]  ef;
      logic [32:0] pk;
      if (s2_exp_ff < 11'sd1) begin
         shamt = 11'd1 - 11'(s2_exp_ff);
         sh    = (shamt > 11'd50) ? 6'd50 : shamt[5:0];
         ef    = 10'd0;
      end else begin
         shamt = 11'd0;
         sh    = shamt[5:0];
         ef    = s2_exp_ff[9:0];
      end
      ext = {s2_mant_ff, 50'd0} >> sh;
      ms  = ext[97:50];
      st  = |ext[49:0];
      inc = ms[23] & ((|ms[22:0]) | st | ms[24]);
      pk  = {ef, ms[46:24]} + 33'(inc);
      if (s2_nan_ff) begin
         s3_result_in = FP32_QNAN;
      end else if (s2_inf_ff) begin
         s3_result_in = {s2_sign_ff, 8'hFF, 23'd0};
      end else if (s2_zero_ff) begin
         s3_result_in = {s2_sign_ff, 31'd0};
      end else if (pk[32:23] >= 10'd255) begin
         s3_result_in = {s2_sign_ff, 8'hFF, 23'd0};
      end else begin
         s3_result_in = {s2_sign_ff, pk[30:0]};
      end
   end

   // Pipeline registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= req.start;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s2_valid_ff;
      end
      if (req.start) begin
         s0_op_ff <= req.op;
         s0_a_ff  <= req.a;
         s0_b_ff  <= req.b;
      end
      s1_sign_ff   <= s1_sign_in;
      s1_exp_ff    <= s1_exp_in;
      s1_mant_ff   <= s1_mant_in;
      s1_nan_ff    <= s1_nan_in;
      s1_inf_ff    <= s1_inf_in;
      s2_sign_ff   <= s1_sign_ff;
      s2_exp_ff    <= s2_exp_in;
      s2_mant_ff   <= s2_mant_in;
      s2_nan_ff    <= s1_nan_ff;
      s2_inf_ff    <= s1_inf_ff;
      s2_zero_ff   <= s2_zero_in;
      s3_result_ff <= s3_result_in;
   end

   assign rsp.done   = s3_valid_ff;
   assign rsp.result = s3_result_ff;

endmodule
